// ===== rtl/swdl_pkg.sv =====
// Shared constants, codes and types for the single-wire debug link master.
package swdl_pkg;

    localparam int ADDR_BITS      = 7;
    localparam int HDR_BITS       = ADDR_BITS + 2;
    localparam int DATA_BITS_DEF  = 32;
    localparam int FIFO_DEPTH_DEF = 4;

    localparam int CMD_W      = 2;
    localparam int WORD_W     = 32;
    localparam int PULSE_W    = 8;
    localparam int TICK_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SHORT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD     = 3'd4;

    localparam logic [PULSE_W-1:0] SHORT_RST     = 8'd1;
    localparam logic [PULSE_W-1:0] LONG_RST      = 8'd32;
    localparam logic [PULSE_W-1:0] THRESHOLD_RST = 8'd4;
    localparam logic [TICK_W-1:0]  TIMEOUT_RST   = 16'd144;
    localparam logic [TICK_W-1:0]  GUARD_RST     = 16'd96;

    typedef struct packed {
        logic                 start;
        logic                 is_read;
        logic [ADDR_BITS-1:0] reg_address;
        logic [WORD_W-1:0]    write_data;
        logic                 line_in;
    } t_swdl_item;

    typedef struct packed {
        logic              drive_low;
        logic              busy_res;
        logic              done_res;
        logic              success;
        logic [WORD_W-1:0] read_data;
    } t_swdl_res;

endpackage

// ===== rtl/swdl_if.sv =====
// Valid/ready channel interfaces for tick transactions and result transactions.
interface swdl_in_if import swdl_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [ADDR_BITS-1:0] reg_address;
    logic [WORD_W-1:0]    write_data;
    logic                 line_in;

    modport source (output valid, output command, output reg_address, output write_data,
                    output line_in, input ready);
    modport sink   (input valid, input command, input reg_address, input write_data,
                    input line_in, output ready);
endinterface

interface swdl_res_if import swdl_pkg::*;;
    logic              valid;
    logic              ready;
    logic              drive_low;
    logic              busy_res;
    logic              done_res;
    logic              success;
    logic [WORD_W-1:0] read_data;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output success, output read_data, input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input success, input read_data, output ready);
endinterface

// ===== rtl/swdl_front.sv =====
// Front stage: accept tick transactions, decode the command and register the item.
module swdl_front import swdl_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    swdl_in_if.sink        i_item,
    output logic           o_valid,
    output t_swdl_item     o_item,
    input  logic           i_ready
);

    logic       r_valid;
    logic       n_valid;
    t_swdl_item r_item;
    t_swdl_item n_item;
    logic       take;

    assign i_item.ready = !r_valid || i_ready;
    assign take         = i_item.valid && i_item.ready;

    always_comb begin
        n_item             = r_item;
        n_valid            = r_valid && !i_ready;
        if (take) begin
            n_valid            = 1'b1;
            n_item.reg_address = i_item.reg_address;
            n_item.write_data  = i_item.write_data;
            n_item.line_in     = i_item.line_in;
            case (i_item.command)
                CMD_TICK: begin
                    n_item.start   = 1'b0;
                    n_item.is_read = 1'b0;
                end
                CMD_WRITE: begin
                    n_item.start   = 1'b1;
                    n_item.is_read = 1'b0;
                end
                CMD_READ: begin
                    n_item.start   = 1'b1;
                    n_item.is_read = 1'b1;
                end
                default: begin
                    n_item.start   = 1'b0;
                    n_item.is_read = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/swdl_fifo.sv =====
// Short queue of decoded items between the front stage and the engine.
module swdl_fifo import swdl_pkg::*; #(
    parameter int DEPTH = FIFO_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_swdl_item i_item,
    output logic       o_ready,
    output logic       o_valid,
    output t_swdl_item o_item,
    input  logic       i_pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    t_swdl_item       r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_count != FULL);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== rtl/swdl_engine.sv =====
// Back stage: configuration registers, frame sequencer and registered result transaction.
module swdl_engine import swdl_pkg::*; #(
    parameter int DATA_BITS = DATA_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    input  t_swdl_item            i_item,
    output logic                  o_pop,
    swdl_res_if.source            o_res
);

    localparam int SEND_W = HDR_BITS + DATA_BITS;
    localparam int BI_W   = $clog2(SEND_W + 1);
    localparam logic [BI_W-1:0] HDR_TOTAL  = BI_W'(HDR_BITS);
    localparam logic [BI_W-1:0] WR_TOTAL   = BI_W'(SEND_W);
    localparam logic [BI_W-1:0] RD_TOTAL   = BI_W'(DATA_BITS);
    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SEND_LOW,
        PH_SEND_HIGH,
        PH_READ_LOW,
        PH_READ_WAIT,
        PH_GUARD
    } t_phase;

    logic [PULSE_W-1:0] r_short;
    logic [PULSE_W-1:0] r_long;
    logic [PULSE_W-1:0] r_threshold;
    logic [TICK_W-1:0]  r_timeout;
    logic [TICK_W-1:0]  r_guard;

    t_phase             r_phase;
    t_phase             n_phase;
    logic [BI_W-1:0]    r_bi;
    logic [BI_W-1:0]    n_bi;
    logic [TICK_W-1:0]  r_tick;
    logic [TICK_W-1:0]  n_tick;
    logic [SEND_W-1:0]  r_send;
    logic [SEND_W-1:0]  n_send;
    logic [WORD_W-1:0]  r_read;
    logic [WORD_W-1:0]  n_read;
    logic               r_is_read;
    logic               n_is_read;
    logic               r_out_valid;
    logic               n_out_valid;
    t_swdl_res          r_out;
    t_swdl_res          n_out;

    logic               pop;
    logic               drive;
    logic               busy;
    logic               done;
    logic               ok;
    logic [TICK_W-1:0]  tick_inc;
    logic [BI_W-1:0]    bi_inc;
    logic [PULSE_W-1:0] dur;

    assign pop   = i_valid && (!r_out_valid || o_res.ready);
    assign o_pop = pop;

    always_comb begin
        n_phase     = r_phase;
        n_bi        = r_bi;
        n_tick      = r_tick;
        n_send      = r_send;
        n_read      = r_read;
        n_is_read   = r_is_read;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out       = r_out;
        drive       = 1'b0;
        busy        = 1'b0;
        done        = 1'b0;
        ok          = 1'b0;
        tick_inc    = '0;
        bi_inc      = '0;
        dur         = '0;
        if (pop) begin
            if (r_phase == PH_IDLE && i_item.start) begin
                n_is_read = i_item.is_read;
                n_send    = {1'b1, i_item.reg_address, !i_item.is_read,
                             i_item.is_read ? {DATA_BITS{1'b0}}
                                            : i_item.write_data[DATA_BITS-1:0]};
                if (i_item.is_read) begin
                    n_read = '0;
                end
                n_bi    = '0;
                n_tick  = '0;
                n_phase = PH_SEND_LOW;
            end
            busy     = (n_phase != PH_IDLE);
            tick_inc = n_tick + 1'b1;
            bi_inc   = n_bi + 1'b1;
            case (n_phase)
                PH_SEND_LOW: begin
                    drive = 1'b1;
                    dur   = n_send[SEND_W-1] ? r_short : r_long;
                    if (tick_inc >= TICK_W'(dur)) begin
                        n_phase = PH_SEND_HIGH;
                        n_tick  = '0;
                    end else begin
                        n_tick = tick_inc;
                    end
                end
                PH_SEND_HIGH: begin
                    if (tick_inc >= TICK_W'(r_short)) begin
                        n_tick = '0;
                        n_send = {n_send[SEND_W-2:0], 1'b0};
                        if (bi_inc >= (n_is_read ? HDR_TOTAL : WR_TOTAL)) begin
                            n_bi = '0;
                            if (n_is_read) begin
                                n_phase = PH_READ_LOW;
                            end else if (r_guard == '0) begin
                                n_phase = PH_IDLE;
                                done    = 1'b1;
                                ok      = 1'b1;
                            end else begin
                                n_phase = PH_GUARD;
                            end
                        end else begin
                            n_bi    = bi_inc;
                            n_phase = PH_SEND_LOW;
                        end
                    end else begin
                        n_tick = tick_inc;
                    end
                end
                PH_READ_LOW: begin
                    drive = 1'b1;
                    if (tick_inc >= TICK_W'(r_short)) begin
                        n_phase = PH_READ_WAIT;
                        n_tick  = '0;
                    end else begin
                        n_tick = tick_inc;
                    end
                end
                PH_READ_WAIT: begin
                    if (i_item.line_in) begin
                        n_read = {n_read[WORD_W-2:0], (n_tick < TICK_W'(r_threshold))};
                        n_tick = '0;
                        if (bi_inc >= RD_TOTAL) begin
                            n_bi = '0;
                            if (r_guard == '0) begin
                                n_phase = PH_IDLE;
                                done    = 1'b1;
                                ok      = 1'b1;
                            end else begin
                                n_phase = PH_GUARD;
                            end
                        end else begin
                            n_bi    = bi_inc;
                            n_phase = PH_READ_LOW;
                        end
                    end else if (n_tick > r_timeout || n_tick == TICK_MAX) begin
                        n_phase = PH_IDLE;
                        n_tick  = '0;
                        n_bi    = '0;
                        done    = 1'b1;
                    end else begin
                        n_tick = tick_inc;
                    end
                end
                PH_GUARD: begin
                    if (tick_inc >= r_guard) begin
                        n_phase = PH_IDLE;
                        n_tick  = '0;
                        done    = 1'b1;
                        ok      = 1'b1;
                    end else begin
                        n_tick = tick_inc;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
            n_out_valid     = 1'b1;
            n_out.drive_low = drive;
            n_out.busy_res  = busy;
            n_out.done_res  = done;
            n_out.success   = done && ok;
            n_out.read_data = n_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short     <= SHORT_RST;
            r_long      <= LONG_RST;
            r_threshold <= THRESHOLD_RST;
            r_timeout   <= TIMEOUT_RST;
            r_guard     <= GUARD_RST;
            r_phase     <= PH_IDLE;
            r_bi        <= '0;
            r_tick      <= '0;
            r_send      <= '0;
            r_read      <= '0;
            r_is_read   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SHORT:     r_short     <= i_cfg_data[PULSE_W-1:0];
                    CFG_LONG:      r_long      <= i_cfg_data[PULSE_W-1:0];
                    CFG_THRESHOLD: r_threshold <= i_cfg_data[PULSE_W-1:0];
                    CFG_TIMEOUT:   r_timeout   <= i_cfg_data[TICK_W-1:0];
                    CFG_GUARD:     r_guard     <= i_cfg_data[TICK_W-1:0];
                    default:       r_guard     <= r_guard;
                endcase
            end
            r_phase     <= n_phase;
            r_bi        <= n_bi;
            r_tick      <= n_tick;
            r_send      <= n_send;
            r_read      <= n_read;
            r_is_read   <= n_is_read;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.drive_low = r_out.drive_low;
    assign o_res.busy_res  = r_out.busy_res;
    assign o_res.done_res  = r_out.done_res;
    assign o_res.success   = r_out.success;
    assign o_res.read_data = r_out.read_data;

endmodule

// ===== rtl/single_wire_debug_link_master_unit.sv =====
// Top level of the single-wire debug link master.
// Each input transaction is one timer tick and yields exactly one result transaction that
// carries the wire drive, busy, done and success flags and the read word. The block takes
// one tick per clock cycle when the result side keeps up: a registered front stage decodes
// the command, a FIFO_DEPTH-entry queue decouples it from the frame engine, and the engine
// advances the link by one tick per cycle into a result register. A tick passes the front
// register, the queue and the result register in turn. The user must write configuration
// registers via the plain write port while no tick is in flight; the block does not enforce it.
module single_wire_debug_link_master_unit import swdl_pkg::*; #(
    parameter int DATA_BITS  = DATA_BITS_DEF,
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    swdl_in_if.sink               i_item,
    swdl_res_if.source            o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic       front_valid;
    t_swdl_item front_item;
    logic       fifo_ready;
    logic       fifo_valid;
    t_swdl_item fifo_item;
    logic       engine_pop;

    swdl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .o_valid (front_valid),
        .o_item  (front_item),
        .i_ready (fifo_ready)
    );

    swdl_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_item  (front_item),
        .o_ready (fifo_ready),
        .o_valid (fifo_valid),
        .o_item  (fifo_item),
        .i_pop   (engine_pop)
    );

    swdl_engine #(
        .DATA_BITS (DATA_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (fifo_valid),
        .i_item      (fifo_item),
        .o_pop       (engine_pop),
        .o_res       (o_res)
    );

endmodule

// ===== rtl/swdl_checker.sv =====
// Port-level checker for the link master, bound to the top level.
module swdl_checker import swdl_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_res_valid,
    input logic              i_res_ready,
    input logic              i_drive_low,
    input logic              i_busy_res,
    input logic              i_done_res,
    input logic              i_success,
    input logic [WORD_W-1:0] i_read_data
);

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_res_valid)
        else $error("result transaction right after reset");

    a_success_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_success |-> i_done_res)
        else $error("success without frame end");

    a_done_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_done_res |-> i_busy_res)
        else $error("frame end outside a busy tick");

    a_drive_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_drive_low |-> i_busy_res && !i_done_res)
        else $error("wire driven outside a frame");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_read_data))
        else $error("stalled result transaction changed");

endmodule

bind single_wire_debug_link_master_unit swdl_checker u_swdl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_drive_low (o_res.drive_low),
    .i_busy_res  (o_res.busy_res),
    .i_done_res  (o_res.done_res),
    .i_success   (o_res.success),
    .i_read_data (o_res.read_data)
);
